### src/ltsc_pkg.sv
// Shared types, codes and keyword table of the language token scanner.
package ltsc_pkg;

    typedef enum logic [4:0] {
        M_IDLE, M_COMMENT, M_EQ, M_BANG, M_GT, M_LT, M_BAR, M_AMP,
        M_INT, M_FLOAT, M_NAME, M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC,
        M_CHR_CLOSE, M_ERR_CHAR, M_ERR_NAME, M_ERR_UNCLOSED
    } mode_t;

    localparam logic [5:0] T_EOF    = 6'd0;
    localparam logic [5:0] T_ASSIGN = 6'd7;
    localparam logic [5:0] T_EQU    = 6'd8;
    localparam logic [5:0] T_NEG    = 6'd9;
    localparam logic [5:0] T_NEQ    = 6'd10;
    localparam logic [5:0] T_GT     = 6'd11;
    localparam logic [5:0] T_GE     = 6'd12;
    localparam logic [5:0] T_LT     = 6'd13;
    localparam logic [5:0] T_LE     = 6'd14;
    localparam logic [5:0] T_BOR    = 6'd15;
    localparam logic [5:0] T_LOR    = 6'd16;
    localparam logic [5:0] T_BAND   = 6'd17;
    localparam logic [5:0] T_LAND   = 6'd18;
    localparam logic [5:0] T_INT    = 6'd28;
    localparam logic [5:0] T_FLOAT  = 6'd29;
    localparam logic [5:0] T_STR    = 6'd30;
    localparam logic [5:0] T_CHAR   = 6'd31;
    localparam logic [5:0] KW_FIRST = 6'd32;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_CHAR     = 3'd1;
    localparam logic [2:0] E_NAME     = 3'd2;
    localparam logic [2:0] E_UNCLOSED = 3'd3;
    localparam logic [2:0] E_CUT      = 3'd4;

    localparam int KW_COUNT   = 21;
    localparam int FIFO_DEPTH = 4;

    // Names are shifted in with the newest letter in the low byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("var"), 64'("const"), 64'("function"), 64'("class"), 64'("union"),
        64'("if"), 64'("else"), 64'("match"), 64'("while"), 64'("for"),
        64'("break"), 64'("continue"), 64'("return"), 64'("void"), 64'("bool"),
        64'("int32"), 64'("uint8"), 64'("char"), 64'("fp32"), 64'("fp64"),
        64'("str")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd8, 4'd5, 4'd5, 4'd2, 4'd4, 4'd5, 4'd5, 4'd3,
        4'd5, 4'd8, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd3
    };

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] lit;
        logic       is_lit;
        logic [2:0] err;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       emit;
        logic [5:0] kind;
        logic       is_lit;
        mode_t      mode;
        logic       name;
    } start_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
    } kw_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic kw_t kw_find(input logic [63:0] letters, input logic [3:0] len);
        kw_t r;
        r = '{hit: 1'b0, kind: T_EOF};
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && letters == KW_TEXT[i]) begin
                r.hit  = 1'b1;
                r.kind = KW_FIRST + 6'(i);
            end
        end
        return r;
    endfunction

    function automatic start_t start_token(input logic [7:0] b);
        start_t s;
        s = '{emit: 1'b0, kind: T_EOF, is_lit: 1'b0, mode: M_IDLE, name: 1'b0};
        case (b)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: s.mode = M_IDLE;
            "#":  s.mode = M_COMMENT;
            "(":  begin s.emit = 1'b1; s.kind = 6'd1;  end
            ")":  begin s.emit = 1'b1; s.kind = 6'd2;  end
            "{":  begin s.emit = 1'b1; s.kind = 6'd3;  end
            "}":  begin s.emit = 1'b1; s.kind = 6'd4;  end
            "[":  begin s.emit = 1'b1; s.kind = 6'd5;  end
            "]":  begin s.emit = 1'b1; s.kind = 6'd6;  end
            "^":  begin s.emit = 1'b1; s.kind = 6'd19; end
            "+":  begin s.emit = 1'b1; s.kind = 6'd20; end
            "-":  begin s.emit = 1'b1; s.kind = 6'd21; end
            "*":  begin s.emit = 1'b1; s.kind = 6'd22; end
            "/":  begin s.emit = 1'b1; s.kind = 6'd23; end
            "%":  begin s.emit = 1'b1; s.kind = 6'd24; end
            ",":  begin s.emit = 1'b1; s.kind = 6'd25; end
            ":":  begin s.emit = 1'b1; s.kind = 6'd26; end
            ";":  begin s.emit = 1'b1; s.kind = 6'd27; end
            "=":  s.mode = M_EQ;
            "!":  s.mode = M_BANG;
            ">":  s.mode = M_GT;
            "<":  s.mode = M_LT;
            "|":  s.mode = M_BAR;
            "&":  s.mode = M_AMP;
            8'h22: s.mode = M_STR;
            8'h27: s.mode = M_CHR_OPEN;
            default: begin
                if (is_digit(b)) begin
                    s.emit   = 1'b1;
                    s.is_lit = 1'b1;
                    s.mode   = M_INT;
                end else if (is_letter(b)) begin
                    s.name = 1'b1;
                    s.mode = M_NAME;
                end else begin
                    s.mode = M_ERR_CHAR;
                end
            end
        endcase
        return s;
    endfunction

endpackage

### src/language_token_scanner_core.sv
// Top level of the language token scanner: scan logic and result queue.
// A byte's results are registered in the result queue, then offered on m_axis.
// Throughput: one byte per cycle while the four-entry result queue has room for two
// results; a byte may cause two, drained one per cycle while m_axis_tready is high.
// Reset (aresetn low, synchronous): scan mode idle, name buffer cleared,
// result queue emptied.
module language_token_scanner_core #(
    parameter int FifoDepth = ltsc_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] token_kind, [13:6] literal_byte,
                                        // [16:14] error_code, rest zero
    output logic        m_axis_tuser,   // is_literal_byte
    output logic        m_axis_tlast    // last_result
);
    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = $clog2(FifoDepth + 1);

    ltsc_pkg::mode_t   mode_reg, mode_next;
    logic [63:0]       letters_reg, letters_next;
    logic [3:0]        len_reg, len_next;

    ltsc_pkg::result_t fifo_reg [FifoDepth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;

    ltsc_pkg::result_t res0, res1;
    logic [1:0]        n_res;
    logic              in_xfer, out_xfer;
    logic [7:0]        b;

    assign b        = s_axis_tdata;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Accept while two slots are free, so a byte's results never overflow.
    assign s_axis_tready = (count_reg <= CntW'(FifoDepth - 2));

    // Scan one byte: compute the next mode and up to two results.
    always_comb begin
        ltsc_pkg::start_t  st;
        ltsc_pkg::kw_t     kw;
        ltsc_pkg::result_t r [2];
        logic [1:0]        n;
        logic              do_start;
        logic [5:0]        pend_kind, pend_pair_kind;
        logic [7:0]        pend_pair;
        logic              is_pend;

        st = ltsc_pkg::start_token(b);
        kw = ltsc_pkg::kw_find(letters_reg, len_reg);
        r[0] = '0;
        r[1] = '0;
        n = 2'd0;
        do_start = 1'b0;
        mode_next = mode_reg;
        letters_next = letters_reg;
        len_next = len_reg;
        is_pend = 1'b1;
        pend_pair = "=";
        pend_kind = ltsc_pkg::T_ASSIGN;
        pend_pair_kind = ltsc_pkg::T_EQU;

        case (mode_reg)
            ltsc_pkg::M_EQ:   ;
            ltsc_pkg::M_BANG: begin
                pend_kind = ltsc_pkg::T_NEG; pend_pair_kind = ltsc_pkg::T_NEQ;
            end
            ltsc_pkg::M_GT:   begin
                pend_kind = ltsc_pkg::T_GT; pend_pair_kind = ltsc_pkg::T_GE;
            end
            ltsc_pkg::M_LT:   begin
                pend_kind = ltsc_pkg::T_LT; pend_pair_kind = ltsc_pkg::T_LE;
            end
            ltsc_pkg::M_BAR:  begin
                pend_pair = "|";
                pend_kind = ltsc_pkg::T_BOR; pend_pair_kind = ltsc_pkg::T_LOR;
            end
            ltsc_pkg::M_AMP:  begin
                pend_pair = "&";
                pend_kind = ltsc_pkg::T_BAND; pend_pair_kind = ltsc_pkg::T_LAND;
            end
            default: is_pend = 1'b0;
        endcase

        if (s_axis_tlast) begin
            // End of input: flush the pending token, then eof with any error.
            r[1].kind = ltsc_pkg::T_EOF;
            r[1].err  = ltsc_pkg::E_NONE;
            n = 2'd1;
            if (is_pend) begin
                r[0].kind = pend_kind;
                n = 2'd2;
            end else begin
                case (mode_reg)
                    ltsc_pkg::M_INT:   begin r[0].kind = ltsc_pkg::T_INT; n = 2'd2; end
                    ltsc_pkg::M_FLOAT: begin r[0].kind = ltsc_pkg::T_FLOAT; n = 2'd2; end
                    ltsc_pkg::M_NAME: begin
                        if (kw.hit) begin
                            r[0].kind = kw.kind;
                            n = 2'd2;
                        end else begin
                            r[1].err = ltsc_pkg::E_NAME;
                        end
                    end
                    ltsc_pkg::M_STR, ltsc_pkg::M_STR_ESC, ltsc_pkg::M_CHR_OPEN,
                    ltsc_pkg::M_CHR_ESC, ltsc_pkg::M_CHR_CLOSE:
                        r[1].err = ltsc_pkg::E_CUT;
                    ltsc_pkg::M_ERR_CHAR:     r[1].err = ltsc_pkg::E_CHAR;
                    ltsc_pkg::M_ERR_NAME:     r[1].err = ltsc_pkg::E_NAME;
                    ltsc_pkg::M_ERR_UNCLOSED: r[1].err = ltsc_pkg::E_UNCLOSED;
                    default: ;
                endcase
            end
            if (n == 2'd1) begin
                r[0] = r[1];
            end
            mode_next = ltsc_pkg::M_IDLE;
            letters_next = '0;
            len_next = '0;
        end else if (is_pend) begin
            if (b == pend_pair) begin
                r[0].kind = pend_pair_kind;
                n = 2'd1;
                mode_next = ltsc_pkg::M_IDLE;
            end else begin
                r[0].kind = pend_kind;
                n = 2'd1;
                do_start = 1'b1;
            end
        end else begin
            case (mode_reg)
                ltsc_pkg::M_IDLE: do_start = 1'b1;
                ltsc_pkg::M_COMMENT: begin
                    if (b == 8'h0A) mode_next = ltsc_pkg::M_IDLE;
                end
                ltsc_pkg::M_INT: begin
                    if (ltsc_pkg::is_digit(b) || b == ".") begin
                        r[0].lit = b; r[0].is_lit = 1'b1; n = 2'd1;
                        if (b == ".") mode_next = ltsc_pkg::M_FLOAT;
                    end else begin
                        r[0].kind = ltsc_pkg::T_INT; n = 2'd1; do_start = 1'b1;
                    end
                end
                ltsc_pkg::M_FLOAT: begin
                    if (ltsc_pkg::is_digit(b)) begin
                        r[0].lit = b; r[0].is_lit = 1'b1; n = 2'd1;
                    end else begin
                        r[0].kind = ltsc_pkg::T_FLOAT; n = 2'd1; do_start = 1'b1;
                    end
                end
                ltsc_pkg::M_NAME: begin
                    if (ltsc_pkg::is_letter(b) || ltsc_pkg::is_digit(b)) begin
                        if (len_reg < 4'd8) letters_next = {letters_reg[55:0], b};
                        if (len_reg < 4'd9) len_next = len_reg + 4'd1;
                    end else begin
                        letters_next = '0;
                        len_next = '0;
                        if (kw.hit) begin
                            r[0].kind = kw.kind; n = 2'd1; do_start = 1'b1;
                        end else begin
                            mode_next = ltsc_pkg::M_ERR_NAME;
                        end
                    end
                end
                ltsc_pkg::M_STR: begin
                    if (b == 8'h22) begin
                        r[0].kind = ltsc_pkg::T_STR; n = 2'd1;
                        mode_next = ltsc_pkg::M_IDLE;
                    end else begin
                        r[0].lit = b; r[0].is_lit = 1'b1; n = 2'd1;
                        if (b == 8'h5C) mode_next = ltsc_pkg::M_STR_ESC;
                    end
                end
                ltsc_pkg::M_STR_ESC: begin
                    r[0].lit = b; r[0].is_lit = 1'b1; n = 2'd1;
                    mode_next = ltsc_pkg::M_STR;
                end
                ltsc_pkg::M_CHR_OPEN: begin
                    if (b == 8'h5C) begin
                        mode_next = ltsc_pkg::M_CHR_ESC;
                    end else begin
                        r[0].lit = b; r[0].is_lit = 1'b1; n = 2'd1;
                        mode_next = ltsc_pkg::M_CHR_CLOSE;
                    end
                end
                ltsc_pkg::M_CHR_ESC: begin
                    // Map the escapes for newline and carriage return.
                    r[0].lit = (b == "n") ? 8'd10 : ((b == "r") ? 8'd13 : b);
                    r[0].is_lit = 1'b1; n = 2'd1;
                    mode_next = ltsc_pkg::M_CHR_CLOSE;
                end
                ltsc_pkg::M_CHR_CLOSE: begin
                    if (b == 8'h27) begin
                        r[0].kind = ltsc_pkg::T_CHAR; n = 2'd1;
                        mode_next = ltsc_pkg::M_IDLE;
                    end else begin
                        mode_next = ltsc_pkg::M_ERR_UNCLOSED;
                    end
                end
                default: ;  // sticky error modes drop every byte
            endcase
        end

        // Scan the byte that ended a token, or a byte seen while idle, as a token start.
        if (do_start) begin
            mode_next = st.mode;
            if (st.emit) begin
                r[n[0]].kind   = st.kind;
                r[n[0]].is_lit = st.is_lit;
                r[n[0]].lit    = st.is_lit ? b : 8'd0;
                n = n + 2'd1;
            end
            if (st.name) begin
                letters_next = {56'd0, b};
                len_next = 4'd1;
            end
        end

        if (n == 2'd2) r[1].last = 1'b1;
        else if (n == 2'd1) r[0].last = 1'b1;

        res0  = r[0];
        res1  = r[1];
        n_res = n;
    end

    // Advance scan state on each byte transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ltsc_pkg::M_IDLE;
            letters_reg <= '0;
            len_reg     <= '0;
        end else if (in_xfer) begin
            mode_reg    <= mode_next;
            letters_reg <= letters_next;
            len_reg     <= len_next;
        end
    end

    // Result queue: push up to two results, pop one per output transfer.
    always_ff @(posedge aclk) begin
        if (in_xfer && n_res != 2'd0) fifo_reg[wr_ptr_reg] <= res0;
        if (in_xfer && n_res == 2'd2) fifo_reg[wr_ptr_reg + PtrW'(1)] <= res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_xfer) wr_ptr_reg <= wr_ptr_reg + PtrW'(n_res);
            if (out_xfer) rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            count_reg <= count_reg + CntW'(in_xfer ? n_res : 2'd0) - CntW'(out_xfer);
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {7'd0, fifo_reg[rd_ptr_reg].err, fifo_reg[rd_ptr_reg].lit,
                            fifo_reg[rd_ptr_reg].kind};
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].is_lit;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

### src/ltsc_checker.sv
// Port-level assertions for the language token scanner, bound to the top level.
module ltsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    // Queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("results offered after reset");

    // Stalled results hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Literal-byte results carry no kind and no error.
    a_lit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] == 6'd0 && m_axis_tdata[16:14] == 3'd0)
        else $error("literal byte result with kind or error");

    // An error shows only on a final eof token.
    a_err_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[16:14] != 3'd0 |->
            !m_axis_tuser && m_axis_tlast && m_axis_tdata[13:0] == 14'd0)
        else $error("error code outside eof result");
endmodule

bind language_token_scanner_core ltsc_checker u_ltsc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
